FILE: rtl/core/sodrl_pkg.sv
// ----------------------------------------------------------------------------
// sodrl_pkg: shared types and constants for the send-on-delta rate limiter
// Payload structs, configuration register map, reset values and Q-format
// constants used by the decision logic and the top level.
// ----------------------------------------------------------------------------
package sodrl_pkg;

  // Request codes carried in req_type
  localparam logic REQ_RESET  = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  // Configuration register map
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 48;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_INTERVAL = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_IDLE     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MOVE_THR_SQ  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_LOOK_DOT_THR = 2'd3;

  // Register reset values
  localparam logic [31:0]        MIN_INTERVAL_RST = 32'd100;
  localparam logic [31:0]        MAX_IDLE_RST     = 32'd250;
  localparam logic [47:0]        MOVE_THR_SQ_RST  = 48'd377487;
  localparam logic signed [29:0] LOOK_DOT_THR_RST = 30'sd268247551;

  // 1.0 in Q2.28, clamp bound for the look dot product
  localparam logic signed [33:0] LOOK_ONE_Q28 = 34'sd268435456;

  // One pose sample
  typedef struct packed {
    logic               req_type;
    logic               link_up;
    logic [63:0]        now_ms;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
  } sample_t;

  // One result
  typedef struct packed {
    logic               transform_valid;
    logic               send_move;
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_pos_z;
    logic signed [15:0] out_dir_x;
    logic signed [15:0] out_dir_y;
    logic signed [15:0] out_dir_z;
  } report_t;

  // Configuration registers as seen by the decision logic
  typedef struct packed {
    logic [31:0]        min_interval_ms;
    logic [31:0]        max_idle_ms;
    logic [47:0]        move_threshold_sq;
    logic signed [29:0] look_dot_threshold;
  } cfg_t;

  // Last sent pose and time; time zero means never sent
  typedef struct packed {
    logic [63:0]        time_ms;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
  } sent_state_t;

endpackage

FILE: rtl/core/sodrl_decide.sv
// ----------------------------------------------------------------------------
// sodrl_decide: send decision for one pose sample
// Computes squared distance, look dot product and elapsed time against the
// last sent pose, decides whether to report, and forms the result and the
// next stored pose.
// ----------------------------------------------------------------------------
module sodrl_decide (
  input  sodrl_pkg::sample_t     sample,
  input  sodrl_pkg::cfg_t        cfg,
  input  sodrl_pkg::sent_state_t sent,
  output sodrl_pkg::report_t     report,
  output sodrl_pkg::sent_state_t sent_next
);
  import sodrl_pkg::*;

  logic signed [32:0] diff_x, diff_y, diff_z;
  logic signed [65:0] sq_x, sq_y, sq_z;
  logic [65:0]        dist_sq;
  logic signed [31:0] prod_x, prod_y, prod_z;
  logic signed [33:0] dot;
  logic signed [29:0] dot_clamped;
  logic [63:0]        elapsed;
  logic               never_sent, idle_hit, min_hit, moved, rotated, send;

  // Position deltas, 33 bits so they never overflow
  assign diff_x = {sample.pos_x[31], sample.pos_x} - {sent.pos_x[31], sent.pos_x};
  assign diff_y = {sample.pos_y[31], sample.pos_y} - {sent.pos_y[31], sent.pos_y};
  assign diff_z = {sample.pos_z[31], sample.pos_z} - {sent.pos_z[31], sent.pos_z};

  // Squares are non-negative; the full-width sum never wraps
  assign sq_x    = diff_x * diff_x;
  assign sq_y    = diff_y * diff_y;
  assign sq_z    = diff_z * diff_z;
  assign dist_sq = 66'(unsigned'(sq_x)) + 66'(unsigned'(sq_y)) + 66'(unsigned'(sq_z));
  assign moved   = dist_sq >= {18'd0, cfg.move_threshold_sq};

  // Look dot product in Q2.28, clamped to plus or minus one
  assign prod_x = sample.dir_x * sent.dir_x;
  assign prod_y = sample.dir_y * sent.dir_y;
  assign prod_z = sample.dir_z * sent.dir_z;
  assign dot    = {{2{prod_x[31]}}, prod_x} + {{2{prod_y[31]}}, prod_y}
                + {{2{prod_z[31]}}, prod_z};

  always_comb begin
    if (dot > LOOK_ONE_Q28) begin
      dot_clamped = LOOK_ONE_Q28[29:0];
    end else if (dot < -LOOK_ONE_Q28) begin
      dot_clamped = 30'(-LOOK_ONE_Q28);
    end else begin
      dot_clamped = dot[29:0];
    end
  end

  assign rotated = dot_clamped <= cfg.look_dot_threshold;

  // Interval checks, elapsed time wraps modulo 2^64
  assign elapsed    = sample.now_ms - sent.time_ms;
  assign never_sent = sent.time_ms == 64'd0;
  assign idle_hit   = elapsed >= {32'd0, cfg.max_idle_ms};
  assign min_hit    = elapsed >= {32'd0, cfg.min_interval_ms};
  assign send       = sample.link_up && (never_sent || idle_hit || (min_hit && (moved || rotated)));

  // Result and next stored pose
  always_comb begin
    report    = '0;
    sent_next = sent;
    if (sample.req_type == REQ_RESET || send) begin
      report.transform_valid = 1'b1;
      report.send_move       = sample.req_type == REQ_SAMPLE;
      report.out_pos_x       = sample.pos_x;
      report.out_pos_y       = sample.pos_y;
      report.out_pos_z       = sample.pos_z;
      report.out_dir_x       = sample.dir_x;
      report.out_dir_y       = sample.dir_y;
      report.out_dir_z       = sample.dir_z;
      sent_next.pos_x        = sample.pos_x;
      sent_next.pos_y        = sample.pos_y;
      sent_next.pos_z        = sample.pos_z;
      sent_next.dir_x        = sample.dir_x;
      sent_next.dir_y        = sample.dir_y;
      sent_next.dir_z        = sample.dir_z;
      sent_next.time_ms      = (sample.req_type == REQ_RESET) ? 64'd0 : sample.now_ms;
    end
  end

endmodule

FILE: rtl/core/send_on_delta_rate_limiter.sv
// ----------------------------------------------------------------------------
// send_on_delta_rate_limiter: pose reporter with minimum and idle intervals
// Input register, combinational send decision, output register; stored pose
// updates as each sample leaves the input register.
// ----------------------------------------------------------------------------
// Takes one pose sample per clock while the output side keeps up and gives
// exactly one result per sample. A sample transfers into the input register,
// is decided there and lands in the output register once that register is free
// or draining. Sustained rate is one sample per cycle when the output side keeps
// up, set by the combinational path that compares a sample against the stored
// pose and writes the new pose back in the same cycle. While a result waits in
// the output register one further sample is still taken and held.
// Configuration writes are meant for idle periods only.
module send_on_delta_rate_limiter (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  sample_valid,
  output logic                                  sample_ready,
  input  sodrl_pkg::sample_t                    sample,
  output logic                                  report_valid,
  input  logic                                  report_ready,
  output sodrl_pkg::report_t                    report,
  input  logic                                  cfg_we,
  input  logic [sodrl_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [sodrl_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import sodrl_pkg::*;

  cfg_t        cfg;
  sent_state_t sent, sent_next;
  sample_t     stage;
  logic        stage_valid;
  logic        advance;
  report_t     report_next;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_interval_ms    <= MIN_INTERVAL_RST;
      cfg.max_idle_ms        <= MAX_IDLE_RST;
      cfg.move_threshold_sq  <= MOVE_THR_SQ_RST;
      cfg.look_dot_threshold <= LOOK_DOT_THR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_INTERVAL: cfg.min_interval_ms    <= cfg_data[31:0];
        CFG_MAX_IDLE:     cfg.max_idle_ms        <= cfg_data[31:0];
        CFG_MOVE_THR_SQ:  cfg.move_threshold_sq  <= cfg_data[47:0];
        CFG_LOOK_DOT_THR: cfg.look_dot_threshold <= cfg_data[29:0];
      endcase
    end
  end

  // Handshake: stage moves on when the output register is free or draining
  assign advance      = stage_valid && (!report_valid || report_ready);
  assign sample_ready = !stage_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (sample_ready) begin
      stage_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_ready && sample_valid) begin
      stage <= sample;
    end
  end

  // Decision logic
  sodrl_decide u_decide (
    .sample    (stage),
    .cfg       (cfg),
    .sent      (sent),
    .report    (report_next),
    .sent_next (sent_next)
  );

  // Stored pose, updated as each sample is decided
  always_ff @(posedge clk) begin
    if (rst) begin
      sent <= '0;
    end else if (advance) begin
      sent <= sent_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      report_valid <= 1'b0;
    end else if (advance) begin
      report_valid <= 1'b1;
    end else if (report_ready) begin
      report_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      report <= report_next;
    end
  end

`ifndef SYNTHESIS
  // A movement send is always a transform update
  a_move_implies_update: assert property (@(posedge clk) disable iff (rst)
    report_valid |-> (!report.send_move || report.transform_valid))
    else $error("send_move without transform_valid");

  // A result with no update carries an all-zero pose
  a_quiet_is_zero: assert property (@(posedge clk) disable iff (rst)
    (report_valid && !report.transform_valid) |->
      (report.out_pos_x == 0 && report.out_pos_y == 0 && report.out_pos_z == 0 &&
       report.out_dir_x == 0 && report.out_dir_y == 0 && report.out_dir_z == 0))
    else $error("pose present on a result without update");

  // A movement send stores the sample time
  a_send_stores_time: assert property (@(posedge clk) disable iff (rst)
    (advance && report_next.send_move) |=> (sent.time_ms == $past(stage.now_ms)))
    else $error("stored time not updated on send");

  // The stored pose changes only when a sample is decided
  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(sent))
    else $error("stored pose changed without a decision");

  // A stalled sample stays in the input register
  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && !advance) |=> (stage_valid && $stable(stage)))
    else $error("stalled sample lost");
`endif

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for send_on_delta_rate_limiter
// Feeds pose samples from a queue through a valid/ready driver, predicts the
// report of every sample transfer with a local send-on-delta model, and
// compares each report transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import sodrl_pkg::*;

  localparam int LIMIT_CYCLES  = 400000;
  localparam int SETTLE_CYCLES = 6;
  localparam int BATCH_LEN     = 43;
  localparam int PRINT_CAP     = 200;

  localparam logic signed [33:0] DOT_UNIT = 34'sd268435456;
  localparam logic signed [29:0] LOOK_MIN = -30'sd268435456;
  localparam logic signed [29:0] LOOK_MAX = 30'sd268435456;
  localparam logic [47:0]        MOVE_MAX = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0]        POS_MAX  = 32'h7FFF_FFFF;
  localparam logic [31:0]        POS_MIN  = 32'h8000_0000;
  localparam logic [15:0]        DIR_ONE  = 16'd16384;
  localparam logic [15:0]        DIR_NEG  = 16'hC000;
  localparam logic [15:0]        DIR_HI   = 16'h7FFF;
  localparam logic [15:0]        DIR_LO   = 16'h8000;

  logic     clk          = 1'b0;
  logic     rst          = 1'b1;
  logic     sample_valid = 1'b0;
  logic     sample_ready;
  sample_t  sample       = '0;
  logic     report_valid;
  logic     report_ready = 1'b0;
  report_t  report;
  logic     cfg_we       = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  send_on_delta_rate_limiter u_top (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .report_valid (report_valid),
    .report_ready (report_ready),
    .report       (report),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #2 clk = ~clk;

  // Pending samples and predicted reports
  sample_t poses_to_send [$];
  report_t reports_due [$];
  report_t want;
  logic    sample_xfer = 1'b0;
  int      errors      = 0;
  int      cycle_count = 0;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;

  // Model copy of the registers and of the last sent pose
  logic [31:0]        lim_min_gap  = 32'd100;
  logic [31:0]        lim_idle     = 32'd250;
  logic [47:0]        lim_move_sq  = 48'd377487;
  logic signed [29:0] lim_look_dot = 30'sd268247551;
  logic signed [31:0] kept_pos [3] = '{default: '0};
  logic signed [15:0] kept_dir [3] = '{default: '0};
  logic [63:0]        kept_time    = '0;

  // Random walk that shapes the well-formed samples
  logic [63:0]        walk_time    = '0;
  logic signed [31:0] walk_pos [3] = '{default: '0};
  logic signed [15:0] walk_dir [3] = '{16'sd16384, 16'sd0, 16'sd0};

  // Send decision for one sample; updates the stored pose on a send
  function automatic report_t decide_report(input sample_t s);
    report_t            r;
    logic signed [31:0] pos [3];
    logic signed [15:0] dir [3];
    logic signed [32:0] diff;
    logic [32:0]        mag;
    logic [66:0]        dist_sq;
    logic signed [33:0] dot;
    logic [63:0]        elapsed;
    logic               moved, rotated, fire;
    int                 i;
    r = '0;
    pos = '{s.pos_x, s.pos_y, s.pos_z};
    dir = '{s.dir_x, s.dir_y, s.dir_z};
    if (s.req_type == REQ_RESET) begin
      fire = 1'b1;
    end else if (!s.link_up) begin
      fire = 1'b0;
    end else begin
      dist_sq = '0;
      dot = '0;
      for (i = 0; i < 3; i++) begin
        diff = {pos[i][31], pos[i]} - {kept_pos[i][31], kept_pos[i]};
        mag = diff[32] ? -diff : diff;
        dist_sq = dist_sq + 67'(mag) * 67'(mag);
        dot = dot + 34'(dir[i]) * 34'(kept_dir[i]);
      end
      if (dot < -DOT_UNIT) dot = -DOT_UNIT;
      if (dot > DOT_UNIT) dot = DOT_UNIT;
      elapsed = s.now_ms - kept_time;
      moved = dist_sq >= 67'(lim_move_sq);
      rotated = dot <= 34'(lim_look_dot);
      fire = (kept_time == '0) || (elapsed >= 64'(lim_idle)) ||
             ((elapsed >= 64'(lim_min_gap)) && (moved || rotated));
    end
    if (fire) begin
      kept_pos = pos;
      kept_dir = dir;
      kept_time = (s.req_type == REQ_RESET) ? '0 : s.now_ms;
      r.transform_valid = 1'b1;
      r.send_move = (s.req_type == REQ_SAMPLE);
      r.out_pos_x = s.pos_x;
      r.out_pos_y = s.pos_y;
      r.out_pos_z = s.pos_z;
      r.out_dir_x = s.dir_x;
      r.out_dir_y = s.dir_y;
      r.out_dir_z = s.dir_z;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (act_val !== exp_val) begin
      if (errors < PRINT_CAP)
        $display("%0t ns: %s mismatch, expected %h actual %h", $time, name, exp_val,
                 act_val);
      errors++;
    end
  endtask

  // Sample transfers feed the predictor; report transfers are checked
  always @(posedge clk) begin
    if (rst) begin
      sample_xfer <= 1'b0;
    end else begin
      sample_xfer <= sample_valid && sample_ready;
      if (sample_valid && sample_ready) reports_due.push_back(decide_report(sample));
      if (report_valid && report_ready) begin
        if (reports_due.size() == 0) begin
          if (errors < PRINT_CAP)
            $display("%0t ns: unexpected report, expected none actual %h", $time, report);
          errors++;
        end else begin
          want = reports_due.pop_front();
          check_field("transform_valid", 32'(want.transform_valid),
                      32'(report.transform_valid));
          check_field("send_move", 32'(want.send_move), 32'(report.send_move));
          check_field("out_pos_x", want.out_pos_x, report.out_pos_x);
          check_field("out_pos_y", want.out_pos_y, report.out_pos_y);
          check_field("out_pos_z", want.out_pos_z, report.out_pos_z);
          check_field("out_dir_x", 32'(want.out_dir_x), 32'(report.out_dir_x));
          check_field("out_dir_y", 32'(want.out_dir_y), 32'(report.out_dir_y));
          check_field("out_dir_z", 32'(want.out_dir_z), 32'(report.out_dir_z));
        end
      end
    end
  end

  // Sample driver: holds each sample until its transfer, idles at random
  always @(negedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (!sample_valid || sample_xfer) begin
      if (poses_to_send.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        sample <= poses_to_send.pop_front();
        sample_valid <= 1'b1;
      end else begin
        sample_valid <= 1'b0;
      end
    end
  end

  // Report side backpressure
  always @(negedge clk) begin
    if (rst) report_ready <= 1'b0;
    else report_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
  end

  // Run time guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic push_sample(input logic req, input logic link, input logic [63:0] now,
                             input logic [31:0] px, input logic [31:0] py,
                             input logic [31:0] pz, input logic [15:0] dx,
                             input logic [15:0] dy, input logic [15:0] dz);
    sample_t s;
    s.req_type = req;
    s.link_up = link;
    s.now_ms = now;
    s.pos_x = px;
    s.pos_y = py;
    s.pos_z = pz;
    s.dir_x = dx;
    s.dir_y = dy;
    s.dir_z = dz;
    poses_to_send.push_back(s);
  endtask

  // Register write; the block is idle, so the model follows at once
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [47:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_MIN_INTERVAL: lim_min_gap = value[31:0];
      CFG_MAX_IDLE:     lim_idle = value[31:0];
      CFG_MOVE_THR_SQ:  lim_move_sq = value;
      CFG_LOOK_DOT_THR: lim_look_dot = value[29:0];
      default: ;
    endcase
  endtask

  task automatic set_limits(input logic [31:0] min_gap, input logic [31:0] idle,
                            input logic [47:0] move_sq, input logic [29:0] look);
    write_reg(CFG_MIN_INTERVAL, {16'd0, min_gap});
    write_reg(CFG_MAX_IDLE, {16'd0, idle});
    write_reg(CFG_MOVE_THR_SQ, move_sq);
    write_reg(CFG_LOOK_DOT_THR, {18'd0, look});
  endtask

  // Hold off until every predicted report has been seen
  task automatic wait_idle();
    while (poses_to_send.size() != 0 || sample_valid || reports_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Random register setting, extremes included
  task automatic choose_limits(input bit use_defaults);
    logic [31:0] min_gap, idle;
    logic [47:0] move_sq;
    logic [29:0] look;
    if (use_defaults) begin
      set_limits(32'd100, 32'd250, 48'd377487, 30'sd268247551);
    end else begin
      case ($urandom_range(3, 0))
        0: min_gap = '0;
        1: min_gap = 32'hFFFF_FFFF;
        default: min_gap = $urandom_range(200, 1);
      endcase
      case ($urandom_range(3, 0))
        0: idle = '0;
        1: idle = 32'hFFFF_FFFF;
        default: idle = $urandom_range(600, 50);
      endcase
      case ($urandom_range(3, 0))
        0: move_sq = '0;
        1: move_sq = MOVE_MAX;
        default: move_sq = 48'($urandom_range(4000000, 0));
      endcase
      case ($urandom_range(4, 0))
        0: look = LOOK_MIN;
        1: look = LOOK_MAX;
        2: look = 30'($urandom_range(536870912, 0) - 268435456);
        default: look = 30'(268435456 - $urandom_range(2000000, 0));
      endcase
      set_limits(min_gap, idle, move_sq, look);
    end
  endtask

  // One random item: mostly a plausible pose walk, some noise and resets
  task automatic add_random_sample();
    int          pick, i;
    logic [63:0] step;
    pick = $urandom_range(99, 0);
    if (pick < 8) begin
      push_sample(1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)), {$urandom, $urandom},
                  $urandom, $urandom, $urandom,
                  16'($urandom), 16'($urandom), 16'($urandom));
    end else begin
      case ($urandom_range(6, 0))
        0: step = 64'($urandom_range(10, 0));
        1: step = 64'(lim_min_gap) + 64'($urandom_range(6, 0)) - 64'd3;
        2: step = 64'(lim_idle) + 64'($urandom_range(6, 0)) - 64'd3;
        3, 4: step = 64'($urandom_range(300, 0));
        5: step = 64'($urandom_range(1000, 0)) - 64'd500;
        default: step = {$urandom, $urandom};
      endcase
      walk_time = walk_time + step;
      for (i = 0; i < 3; i++) begin
        case ($urandom_range(9, 0))
          0: walk_pos[i] = $urandom;
          1, 2: walk_pos[i] = walk_pos[i] + $urandom_range(16000, 0) - 8000;
          default: walk_pos[i] = walk_pos[i] + $urandom_range(1400, 0) - 700;
        endcase
      end
      if ($urandom_range(4, 0) == 0) begin
        for (i = 0; i < 3; i++) walk_dir[i] = 16'($urandom_range(2000, 0)) - 16'd1000;
        walk_dir[2'($urandom_range(2, 0))] = $urandom_range(1, 0) ? DIR_ONE : DIR_NEG;
      end else begin
        for (i = 0; i < 3; i++)
          walk_dir[i] = walk_dir[i] + 16'($urandom_range(300, 0)) - 16'd150;
      end
      if (pick < 12)
        push_sample(REQ_RESET, 1'($urandom_range(1, 0)), walk_time, walk_pos[0],
                    walk_pos[1], walk_pos[2], walk_dir[0], walk_dir[1], walk_dir[2]);
      else
        push_sample(REQ_SAMPLE, pick >= 18, walk_time, walk_pos[0], walk_pos[1],
                    walk_pos[2], walk_dir[0], walk_dir[1], walk_dir[2]);
    end
  endtask

  // Stimulus sequence
  initial begin
    int phase, batch, n;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_idle_pct = 30;
    recv_idle_pct = 30;

    // Reset register values: first sends, intervals, thresholds, clamping, wrap
    push_sample(REQ_SAMPLE, 1'b1, 64'd0, 32'd0, 32'd0, 32'd0, DIR_ONE, 16'd0, 16'd0);
    push_sample(REQ_SAMPLE, 1'b1, 64'd5, 32'd0, 32'd0, 32'd0, DIR_ONE, 16'd0, 16'd0);
    push_sample(REQ_SAMPLE, 1'b1, 64'd10, 32'd100, 32'd0, 32'd0, DIR_ONE, 16'd0, 16'd0);
    push_sample(REQ_SAMPLE, 1'b0, 64'd1000, 32'd16384, 32'd0, 32'd0, 16'd0, DIR_ONE, 16'd0);
    push_sample(REQ_SAMPLE, 1'b1, 64'd60, 32'd16384, 32'd0, 32'd0, DIR_ONE, 16'd0, 16'd0);
    push_sample(REQ_SAMPLE, 1'b1, 64'd105, 32'd16384, 32'd0, 32'd0, DIR_ONE, 16'd0, 16'd0);
    push_sample(REQ_SAMPLE, 1'b1, 64'd210, 32'd16384, 32'd0, 32'd0, 16'd0, DIR_ONE, 16'd0);
    push_sample(REQ_SAMPLE, 1'b1, 64'd300, 32'd16484, 32'd0, 32'd0, 16'd0, DIR_ONE, 16'd0);
    push_sample(REQ_SAMPLE, 1'b1, 64'd460, 32'd16384, 32'd0, 32'd0, 16'd0, DIR_ONE, 16'd0);
    push_sample(REQ_RESET, 1'b0, 64'd777, POS_MAX, POS_MAX, POS_MAX, DIR_LO, DIR_LO, DIR_LO);
    push_sample(REQ_SAMPLE, 1'b1, 64'hFFFF_FFFF_FFFF_FFF0, POS_MAX, POS_MAX, POS_MAX,
                DIR_LO, DIR_LO, DIR_LO);
    push_sample(REQ_SAMPLE, 1'b1, 64'd90, POS_MIN, POS_MIN, POS_MIN, DIR_LO, DIR_LO, DIR_LO);
    push_sample(REQ_SAMPLE, 1'b1, 64'd195, POS_MIN, POS_MIN, POS_MIN, DIR_HI, DIR_HI, DIR_HI);
    push_sample(REQ_SAMPLE, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, POS_MIN, POS_MIN, POS_MIN,
                DIR_HI, DIR_HI, DIR_HI);
    push_sample(REQ_RESET, 1'b1, 64'd0, 32'd0, 32'd0, 32'd0, DIR_ONE, 16'd0, 16'd0);
    push_sample(REQ_SAMPLE, 1'b1, 64'd0, 32'd0, 32'd0, 32'd0, DIR_ONE, 16'd0, 16'd0);
    push_sample(REQ_SAMPLE, 1'b1, 64'd1, 32'd0, 32'd0, 32'd0, DIR_ONE, 16'd0, 16'd0);
    // just under and just over the default move threshold
    push_sample(REQ_SAMPLE, 1'b1, 64'd101, 32'd614, 32'd0, 32'd0, DIR_ONE, 16'd0, 16'd0);
    push_sample(REQ_SAMPLE, 1'b1, 64'd101, 32'd615, 32'd0, 32'd0, DIR_ONE, 16'd0, 16'd0);
    wait_idle();

    // Extreme registers: no minimum gap, longest idle, largest move threshold, lowest look threshold
    set_limits(32'd0, 32'hFFFF_FFFF, MOVE_MAX, LOOK_MIN);
    push_sample(REQ_SAMPLE, 1'b1, 64'd102, 32'd615, 32'd0, 32'd0, DIR_ONE, 16'd0, 16'd0);
    push_sample(REQ_SAMPLE, 1'b1, 64'd103, 32'd615, 32'd0, 32'd0, DIR_NEG, 16'd0, 16'd0);
    push_sample(REQ_SAMPLE, 1'b1, 64'd103, 32'd16777831, 32'd0, 32'd0, DIR_NEG, 16'd0, 16'd0);
    push_sample(REQ_SAMPLE, 1'b1, 64'd103, 32'd33555046, 32'd0, 32'd0, DIR_NEG, 16'd0, 16'd0);
    push_sample(REQ_SAMPLE, 1'b1, 64'h1_0000_0065, 32'd16777831, 32'd0, 32'd0,
                DIR_NEG, 16'd0, 16'd0);
    push_sample(REQ_SAMPLE, 1'b1, 64'h1_0000_0066, 32'd16777831, 32'd0, 32'd0,
                DIR_NEG, 16'd0, 16'd0);
    wait_idle();

    // Random phases: sender idles lightly, then heavily, then no idling at all
    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 74 : 0;
      recv_idle_pct = (phase == 0) ? 74 : (phase == 1) ? 11 : 0;
      for (batch = 0; batch < 4; batch++) begin
        choose_limits(batch == 0);
        for (n = 0; n < BATCH_LEN; n++) add_random_sample();
        wait_idle();
      end
    end

    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
